// File: src/b64enc_pkg.sv
// Shared types and constants for the base64 stream encoder.
// Holds the port payload structs, the queued job record and the alphabet map.
// No dependencies.
`timescale 1ns / 1ps

package b64enc_pkg;

	// Number of character slots one input byte can need.
	localparam int unsigned JOB_SLOTS = 4;

	localparam logic [7:0] CHAR_PAD = 8'h3D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_final;
	} in_item_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_run;
		logic       end_of_message;
	} out_item_t;

	// One classified byte: up to four 6-bit groups, which slots are pads,
	// index of the last slot and the end-of-message mark.
	typedef struct packed {
		logic [JOB_SLOTS-1:0][5:0] idx;
		logic [JOB_SLOTS-1:0]      pad;
		logic [1:0]                last;
		logic                      fin;
	} job_t;

	// Map a 6-bit group to its character in the standard alphabet.
	function automatic logic [7:0] sym_char(input logic [5:0] idx);
		logic [7:0] w;
		logic [7:0] c;
		w = {2'b00, idx};
		priority if (idx < 6'd26) begin
			c = w + 8'd65;
		end else if (idx < 6'd52) begin
			c = w + 8'd71;
		end else if (idx < 6'd62) begin
			c = w - 8'd4;
		end else if (idx == 6'd62) begin
			c = 8'd43;
		end else begin
			c = 8'd47;
		end
		return c;
	endfunction

endpackage

// File: src/b64enc_front.sv
// Front part of the base64 stream encoder: accepts bytes, keeps the leftover
// bits and turns each byte into one job record for the queue.
// Depends on b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  b64enc_pkg::in_item_t byte_item,
	input  logic                 queue_full,
	output logic                 push,
	output b64enc_pkg::job_t     job
);

	typedef enum logic [2:0] {
		LO_NONE = 3'b001,
		LO_TWO  = 3'b010,
		LO_FOUR = 3'b100
	} lo_state_t;

	lo_state_t  lo_state_q;
	lo_state_t  lo_state_d;
	logic [3:0] lo_bits_q;
	logic [3:0] lo_bits_d;
	logic [7:0] b;
	logic       fin;

	assign b          = byte_item.data_byte;
	assign fin        = byte_item.is_final;
	assign byte_stall = queue_full;
	assign push       = byte_valid && !queue_full;

	always_comb begin
		job        = '0;
		job.fin    = fin;
		lo_bits_d  = 4'd0;
		lo_state_d = LO_NONE;
		unique case (lo_state_q)
			LO_TWO: begin
				job.idx[0] = {lo_bits_q[1:0], b[7:4]};
				if (fin) begin
					job.idx[1] = {b[3:0], 2'b00};
					job.pad    = 4'b0100;
					job.last   = 2'd2;
				end else begin
					lo_bits_d  = b[3:0];
					lo_state_d = LO_FOUR;
				end
			end
			LO_FOUR: begin
				job.idx[0] = {lo_bits_q[3:0], b[7:6]};
				job.idx[1] = b[5:0];
				job.last   = 2'd1;
			end
			default: begin
				job.idx[0] = b[7:2];
				if (fin) begin
					job.idx[1] = {b[1:0], 4'b0000};
					job.pad    = 4'b1100;
					job.last   = 2'd3;
				end else begin
					lo_bits_d  = {2'b00, b[1:0]};
					lo_state_d = LO_TWO;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_state_q <= LO_NONE;
			lo_bits_q  <= 4'd0;
		end else if (push) begin
			lo_state_q <= lo_state_d;
			lo_bits_q  <= lo_bits_d;
		end
	end

endmodule

// File: src/b64enc_fifo.sv
// Short job queue between the front and back parts of the base64 encoder.
// Register array with read and write pointers and a fill count.
// Depends on b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  b64enc_pkg::job_t wr_job,
	input  logic             pop,
	output b64enc_pkg::job_t rd_job,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	b64enc_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/b64enc_back.sv
// Back part of the base64 encoder: walks the slots of the head job and puts
// one character a cycle into the output register while not stalled.
// Depends on b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64enc_pkg::job_t      head_job,
	input  logic                  head_empty,
	output logic                  pop,
	output logic                  sym_valid,
	input  logic                  sym_stall,
	output b64enc_pkg::out_item_t sym_item
);

	logic [1:0]            pos_q;
	logic                  valid_q;
	b64enc_pkg::out_item_t item_q;
	logic                  load;
	logic                  at_last;
	logic [7:0]            chr;

	// Output register can take a new character when empty or being drained.
	assign load    = !head_empty && (!valid_q || !sym_stall);
	assign at_last = (pos_q == head_job.last);
	assign pop     = load && at_last;
	assign chr     = head_job.pad[pos_q] ? b64enc_pkg::CHAR_PAD
	                                     : b64enc_pkg::sym_char(head_job.idx[pos_q]);

	assign sym_valid = valid_q;
	assign sym_item  = item_q;

	always_ff @(posedge clk) begin
		if (load) begin
			item_q.symbol         <= chr;
			item_q.end_of_run     <= at_last;
			item_q.end_of_message <= at_last && head_job.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				pos_q   <= at_last ? 2'd0 : pos_q + 2'd1;
			end else if (!sym_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/base64_stream_encoder_unit.sv
// Top level of the base64 stream encoder; instantiates b64enc_front,
// b64enc_fifo and b64enc_back. Depends on b64enc_pkg.
`timescale 1ns / 1ps

// Standard-alphabet base64 encoder for a byte stream. Each request on the
// byte channel carries one message byte and a last-of-message flag; each
// request on the symbol channel carries one ASCII character with an
// end-of-run mark (last character caused by that byte) and an
// end-of-message mark (last character of the encoded message, pads
// included). A non-final byte yields one or two characters; a final byte
// yields two to four, with '=' padding as needed, and the leftover bits then
// return to empty for the next message. The front accepts a byte in every
// cycle while the job queue has room, classifies it against the 0, 2 or 4
// leftover bits and queues one job record; the back emits one character per
// cycle through a registered output while a job waits and the output is not
// stalled. The single-character output port therefore limits throughput: a
// long message yields four characters per three bytes, and a final byte
// after a complete group yields four. When nothing stalls, a byte's first
// character passes through the job queue and then the output register.
// QUEUE_DEPTH sets how many classified bytes can wait between the two parts.
module base64_stream_encoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  b64enc_pkg::in_item_t  byte_item,
	output logic                  sym_valid,
	input  logic                  sym_stall,
	output b64enc_pkg::out_item_t sym_item
);

	b64enc_pkg::job_t wr_job;
	b64enc_pkg::job_t head_job;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             queue_empty;

	// Classify bytes and hold leftover bits; stall only when the queue is full.
	b64enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.queue_full (queue_full),
		.push       (push),
		.job        (wr_job)
	);

	// Decouple the two sides so each may stall on its own.
	b64enc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (head_job),
		.full   (queue_full),
		.empty  (queue_empty)
	);

	// Serialize each job into characters; drop the job after its last slot.
	b64enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.head_empty (queue_empty),
		.pop        (pop),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.sym_item   (sym_item)
	);

endmodule
